### rtl/core/icv_pkg.sv
// Shared types, constants and helpers for the 3x3 valid-mode image convolution block.
`default_nettype none
package icv_pkg;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int CHANNELS   = 3;
   localparam int PIXEL_BITS = 8;
   localparam int PIX_W      = CHANNELS * PIXEL_BITS;
   localparam int SIZE_W     = 11;
   localparam int POS_W      = 10;
   localparam int COEF_W     = 16;
   localparam int ROW_W      = 3 * COEF_W;
   localparam int PROD_W     = COEF_W + PIXEL_BITS + 1;
   localparam int SUM_W      = PROD_W + 4;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_ANCHOR_ROW   = 3'd2,
      CSR_ANCHOR_COL   = 3'd3,
      CSR_COEF_ROW0    = 3'd4,
      CSR_COEF_ROW1    = 3'd5,
      CSR_COEF_ROW2    = 3'd6
   } csr_idx_type;

   typedef logic [PIX_W-1:0] pix_type;

   // line buffer write request
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      pix_type           data;
   } lb_wr_type;

   // clamp a size register to 3..hi
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      if (v < SIZE_W'(3)) r = SIZE_W'(3);
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction
endpackage
`default_nettype wire

### rtl/core/icv_line_buf.sv
// Two line stores with registered read and same-address forwarding.
`default_nettype none
module icv_line_buf (
   input  wire                           clock,
   input  wire                           rd_en,
   input  wire  [icv_pkg::ADDR_W-1:0]    rd_addr,
   input  icv_pkg::lb_wr_type            wr,
   output icv_pkg::pix_type              rd0_q,
   output icv_pkg::pix_type              rd1_q
);
   import icv_pkg::*;

   pix_type line0_mem [MAX_WIDTH];
   pix_type line1_mem [MAX_WIDTH];
   pix_type rd0_ff;
   pix_type rd1_ff;

   // newest line takes the pixel, older line takes what the newest held
   always_ff @(posedge clock) begin
      if (wr.en) begin
         line0_mem[wr.addr] <= wr.data;
         line1_mem[wr.addr] <= rd0_ff;
      end
   end

   // registered read, forwarding a write to the same address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && wr.addr == rd_addr) begin
            rd0_ff <= wr.data;
            rd1_ff <= rd0_ff;
         end else begin
            rd0_ff <= line0_mem[rd_addr];
            rd1_ff <= line1_mem[rd_addr];
         end
      end
   end

   assign rd0_q = rd0_ff;
   assign rd1_q = rd1_ff;
endmodule
`default_nettype wire

### rtl/core/image_convolution_valid_top.sv
// Top level: 3x3 valid-mode correlation over a raster stream of 3-channel pixels.
//
//  channel | dir | transaction payload
//  req_    | in  | tdata: pix_ch0, pix_ch1, pix_ch2; tuser: frame_first
//  rsp_    | out | tdata: out_ch0..2, out_row, out_col; tlast: frame_last
//  csr_    | in  | write enable, register index, 48-bit data
//
// One pixel per cycle sustained while rsp_ is not stalled. Four register stages: line
// store read, window load, product register, sum/round/saturate register; rsp_tvalid
// is driven by the last of them.
// A stalled rsp_ freezes the whole pipeline; req_tready follows rsp_ space.
// Synchronous reset clears counters, valids, window and registers to defaults.
// Line stores are not cleared; each entry is written before its contents can reach an output.
`default_nettype none
module image_convolution_valid_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // pix_ch0, pix_ch1, pix_ch2
   input  wire  [0:0]  req_tuser,   // frame_first
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // out_ch0, out_ch1, out_ch2, out_row, out_col, pad
   output logic        rsp_tlast,   // frame_last
   input  wire         csr_we,
   input  wire  [2:0]  csr_addr,
   input  wire  [47:0] csr_wdata
);
   import icv_pkg::*;

   // configuration
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [1:0]        anchor_row_ff, anchor_col_ff;
   logic [ROW_W-1:0]  coef_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= SIZE_W'(640);
         height_ff     <= SIZE_W'(480);
         anchor_row_ff <= 2'd1;
         anchor_col_ff <= 2'd1;
         coef_ff[0]    <= '0;
         coef_ff[1]    <= ROW_W'(48'd16777216);
         coef_ff[2]    <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_IMAGE_WIDTH:  width_ff      <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_ANCHOR_ROW:   anchor_row_ff <= csr_wdata[1:0];
            CSR_ANCHOR_COL:   anchor_col_ff <= csr_wdata[1:0];
            CSR_COEF_ROW0:    coef_ff[0]    <= csr_wdata[ROW_W-1:0];
            CSR_COEF_ROW1:    coef_ff[1]    <= csr_wdata[ROW_W-1:0];
            CSR_COEF_ROW2:    coef_ff[2]    <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline enable
   logic rsp_valid_ff;
   logic en;
   logic acc;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign acc        = req_tvalid && en;

   // position counters
   logic [POS_W-1:0]  row_ff, col_ff, row_cur, col_cur;
   logic [SIZE_W-1:0] w_lim, h_lim;
   logic              line_end, frame_end, produce;

   always_comb begin
      row_cur   = req_tuser[0] ? '0 : row_ff;
      col_cur   = req_tuser[0] ? '0 : col_ff;
      w_lim     = clamp_size(width_ff, SIZE_W'(MAX_WIDTH));
      h_lim     = clamp_size(height_ff, SIZE_W'(MAX_HEIGHT));
      line_end  = {1'b0, col_cur} >= (w_lim - SIZE_W'(1));
      frame_end = line_end && ({1'b0, row_cur} >= (h_lim - SIZE_W'(1)));
      produce   = row_cur >= POS_W'(2) && col_cur >= POS_W'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (acc) begin
         if (frame_end) begin
            row_ff <= '0;
            col_ff <= '0;
         end else if (line_end) begin
            row_ff <= row_cur + POS_W'(1);
            col_ff <= '0;
         end else begin
            row_ff <= row_cur;
            col_ff <= col_cur + POS_W'(1);
         end
      end
   end

   // stage 1: accepted pixel, line store read in flight
   logic             s1_valid_ff, s1_produce_ff, s1_last_ff;
   pix_type          s1_pix_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [POS_W-1:0] s1_row_ff, s1_col_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (en) s1_valid_ff <= acc;
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff     <= req_tdata;
         s1_addr_ff    <= col_cur[ADDR_W-1:0];
         s1_produce_ff <= produce;
         s1_last_ff    <= frame_end;
         s1_row_ff     <= POS_W'({8'd0, anchor_row_ff} + row_cur - POS_W'(2));
         s1_col_ff     <= POS_W'({8'd0, anchor_col_ff} + col_cur - POS_W'(2));
      end
   end

   lb_wr_type lb_wr;
   pix_type   lb_rd0, lb_rd1;
   assign lb_wr.en   = s1_valid_ff && en;
   assign lb_wr.addr = s1_addr_ff;
   assign lb_wr.data = s1_pix_ff;

   icv_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (acc),
      .rd_addr (col_cur[ADDR_W-1:0]),
      .wr      (lb_wr),
      .rd0_q   (lb_rd0),
      .rd1_q   (lb_rd1)
   );

   // stage 2: window shift and load
   pix_type          win_ff [3][3];
   logic             s2_valid_ff, s2_last_ff;
   logic [POS_W-1:0] s2_row_ff, s2_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               win_ff[r][k] <= '0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff && s1_produce_ff;
         if (s1_valid_ff) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= lb_rd1;
            win_ff[1][2] <= lb_rd0;
            win_ff[2][2] <= s1_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && s1_valid_ff) begin
         s2_last_ff <= s1_last_ff;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
      end
   end

   // stage 3: 27 parallel coefficient x pixel products, operands sign-extended first
   logic signed [PROD_W-1:0] prod_ff [CHANNELS][3][3];
   logic             s3_valid_ff, s3_last_ff;
   logic [POS_W-1:0] s3_row_ff, s3_col_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (en) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en && s2_valid_ff) begin
         s3_last_ff <= s2_last_ff;
         s3_row_ff  <= s2_row_ff;
         s3_col_ff  <= s2_col_ff;
         for (int c = 0; c < CHANNELS; c++)
            for (int r = 0; r < 3; r++)
               for (int k = 0; k < 3; k++)
                  prod_ff[c][r][k] <=
                     PROD_W'($signed(coef_ff[r][k*COEF_W +: COEF_W])) *
                     PROD_W'($signed({1'b0, win_ff[r][k][c*PIXEL_BITS +: PIXEL_BITS]}));
      end
   end

   // stage 4: sum, round half to even, saturate
   logic [PIXEL_BITS-1:0] res_ch [CHANNELS];
   always_comb begin
      logic signed [SUM_W-1:0]    sum;
      logic signed [SUM_W-8:0]    q;
      logic                       inc;
      for (int c = 0; c < CHANNELS; c++) begin
         sum = '0;
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               sum = sum + SUM_W'(prod_ff[c][r][k]);
         inc = (sum[7:0] > 8'd128) || (sum[7:0] == 8'd128 && sum[8]);
         q   = {sum[SUM_W-1], sum[SUM_W-1:8]} + (SUM_W-7)'(inc);
         if (q < 0) res_ch[c] = '0;
         else if (q > (SUM_W-7)'(255)) res_ch[c] = 8'hFF;
         else res_ch[c] = q[PIXEL_BITS-1:0];
      end
   end

   logic [PIX_W-1:0]  rsp_pix_ff;
   logic [POS_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic              rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en && s3_valid_ff) begin
         rsp_pix_ff  <= {res_ch[2], res_ch[1], res_ch[0]};
         rsp_row_ff  <= s3_row_ff;
         rsp_col_ff  <= s3_col_ff;
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_col_ff, rsp_row_ff, rsp_pix_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_frame_implies_line: assert property (@(posedge clock) disable iff (reset)
      acc && frame_end |=> row_ff == '0 && col_ff == '0)
      else $error("frame end did not wrap counters");
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      acc && !line_end |=> col_ff == $past(col_cur) + POS_W'(1))
      else $error("column counter did not advance");
   a_s3_from_s2: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !$past(s3_valid_ff) |-> $past(s2_valid_ff))
      else $error("product stage valid without window stage");
endmodule
`default_nettype wire

### tb/image_convolution_valid_top_tb.sv
// Self-checking testbench for the 3x3 valid-mode image convolution block.
`default_nettype none
module image_convolution_valid_top_tb;
   import icv_pkg::*;

   // Expected result of one output pixel
   typedef struct packed {
      logic [7:0] ch0;
      logic [7:0] ch1;
      logic [7:0] ch2;
      logic [9:0] row;
      logic [9:0] col;
      logic       last;
   } conv_out_type;

   // Scoreboard: own copy of the filter state and a queue of expected pixels
   class conv_scoreboard;
      logic [10:0] width_reg, height_reg;
      logic [1:0]  anc_row, anc_col;
      logic [47:0] coef[3];
      logic [23:0] lines[2][MAX_WIDTH];
      logic [23:0] win[3][3];
      int unsigned row_pos, col_pos;
      conv_out_type pending[$];
      int          errors;

      function void reset_state();
         width_reg = 11'd640;
         height_reg = 11'd480;
         anc_row = 2'd1;
         anc_col = 2'd1;
         coef[0] = '0;
         coef[1] = 48'd16777216;
         coef[2] = '0;
         foreach (lines[i, j]) lines[i][j] = '0;
         foreach (win[i, j]) win[i][j] = '0;
         row_pos = 0;
         col_pos = 0;
         errors = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [47:0] val);
         case (idx)
            CSR_IMAGE_WIDTH:  width_reg = val[10:0];
            CSR_IMAGE_HEIGHT: height_reg = val[10:0];
            CSR_ANCHOR_ROW:   anc_row = val[1:0];
            CSR_ANCHOR_COL:   anc_col = val[1:0];
            CSR_COEF_ROW0:    coef[0] = val;
            CSR_COEF_ROW1:    coef[1] = val;
            CSR_COEF_ROW2:    coef[2] = val;
            default: ;
         endcase
      endfunction

      function int unsigned size_used(logic [10:0] v);
         if (v < 3) return 3;
         if (v > 1024) return 1024;
         return int'(v);
      endfunction

      // Round half to even, then saturate to 8 bits
      function logic [7:0] round_sat(longint s);
         longint q, rem;
         q = s >>> 8;
         rem = s - q * 256;
         if (rem > 128 || (rem == 128 && q[0])) q = q + 1;
         if (q < 0) return 8'd0;
         if (q > 255) return 8'd255;
         return q[7:0];
      endfunction

      // Note an accepted pixel; queue the output it causes, if any
      function void note_pixel(logic [23:0] pix, logic first);
         int unsigned w, h, r, c;
         logic line_end, frame_end;
         longint acc;
         logic [15:0] raw;
         conv_out_type e;
         logic [7:0] chv[3];
         w = size_used(width_reg);
         h = size_used(height_reg);
         if (first) begin
            row_pos = 0;
            col_pos = 0;
         end
         r = row_pos;
         c = col_pos;
         for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
         end
         win[0][2] = lines[1][c];
         win[1][2] = lines[0][c];
         win[2][2] = pix;
         lines[1][c] = lines[0][c];
         lines[0][c] = pix;
         line_end = (c >= w - 1);
         frame_end = line_end && (r >= h - 1);
         if (r >= 2 && c >= 2) begin
            for (int ch = 0; ch < 3; ch++) begin
               acc = 0;
               for (int i = 0; i < 3; i++)
                  for (int k = 0; k < 3; k++) begin
                     raw = coef[i][16*k +: 16];
                     acc += longint'($signed(raw)) * longint'(win[i][k][8*ch +: 8]);
                  end
               chv[ch] = round_sat(acc);
            end
            e.ch0 = chv[0];
            e.ch1 = chv[1];
            e.ch2 = chv[2];
            e.row = 10'(anc_row + r - 2);
            e.col = 10'(anc_col + c - 2);
            e.last = frame_end;
            pending.push_back(e);
         end
         if (frame_end) begin
            row_pos = 0;
            col_pos = 0;
         end else if (line_end) begin
            row_pos = (r + 1) & 10'h3FF;
            col_pos = 0;
         end else begin
            col_pos = (c + 1) & 10'h3FF;
         end
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      // Check one accepted output against the oldest expectation
      task check_output(logic [47:0] data, logic last);
         conv_out_type e;
         if (pending.size() == 0) begin
            report("unexpected transaction", longint'(data), 0);
            return;
         end
         e = pending.pop_front();
         if (data[7:0] !== e.ch0) report("out_ch0", longint'(data[7:0]), longint'(e.ch0));
         if (data[15:8] !== e.ch1) report("out_ch1", longint'(data[15:8]), longint'(e.ch1));
         if (data[23:16] !== e.ch2)
            report("out_ch2", longint'(data[23:16]), longint'(e.ch2));
         if (data[33:24] !== e.row)
            report("out_row", longint'(data[33:24]), longint'(e.row));
         if (data[43:34] !== e.col)
            report("out_col", longint'(data[43:34]), longint'(e.col));
         if (last !== e.last) report("frame_last", longint'(last), longint'(e.last));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // pix_ch0, pix_ch1, pix_ch2
   logic [0:0]  req_tuser = '0;   // frame_first
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;        // out_ch0..2, out_row, out_col, pad
   logic        rsp_tlast;        // frame_last
   logic        csr_we = 0;
   logic [2:0]  csr_addr = '0;
   logic [47:0] csr_wdata = '0;

   conv_scoreboard sb;
   logic stim_done = 0;
   logic hold_off = 0;
   int   burst_left = 0;

   image_convolution_valid_top dut (.*);

   always #2 clock = ~clock;

   // Register write while the block is idle
   task automatic write_csr(csr_idx_type idx, logic [47:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   // Offer one pixel, with bursty gaps; returns once accepted
   task automatic send_pixel(logic [23:0] pix, logic first);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(pix, first);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Send a whole frame of random or extreme content
   task automatic send_frame(int w, int h, int mode);
      logic [23:0] p;
      for (int i = 0; i < w * h; i++) begin
         case (mode)
            0: p = 24'hFFFFFF;
            1: p = 24'h000000;
            default: p = 24'($urandom);
         endcase
         send_pixel(p, i == 0);
      end
   endtask

   function automatic logic [47:0] rand_coef_row();
      logic [47:0] v;
      v = 48'({$urandom, $urandom});
      for (int k = 0; k < 3; k++)
         if ($urandom_range(0, 1)) v[16*k +: 16] = 16'($signed($urandom_range(0, 512)) - 256);
      return v;
   endfunction

   // Receiver: own stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_output(rsp_tdata, rsp_tlast);
      rsp_tready <= !hold_off && ($urandom_range(0, 3) != 0 || stim_done);
   end

   initial begin
      sb = new();
      sb.reset_state();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: smallest frame, saturating and zero pixels, identity kernel
      write_csr(CSR_IMAGE_WIDTH, 48'd3);
      write_csr(CSR_IMAGE_HEIGHT, 48'd3);
      send_frame(3, 3, 0);
      send_frame(3, 3, 1);
      drain();
      // Extreme kernels, clamped width, anchors 0 and 3
      write_csr(CSR_IMAGE_WIDTH, 48'd0);
      write_csr(CSR_IMAGE_HEIGHT, 48'd2047);
      write_csr(CSR_IMAGE_HEIGHT, 48'd4);
      write_csr(CSR_ANCHOR_ROW, 48'd0);
      write_csr(CSR_ANCHOR_COL, 48'd3);
      write_csr(CSR_COEF_ROW0, 48'h7FFF_7FFF_7FFF);
      write_csr(CSR_COEF_ROW1, 48'h8000_8000_8000);
      write_csr(CSR_COEF_ROW2, 48'h0080_0080_0080);
      send_frame(3, 4, 2);
      // frame_first mid-frame restarts the counters
      send_pixel(24'h123456, 1'b0);
      send_pixel(24'hABCDEF, 1'b1);
      send_frame(3, 4, 2);
      drain();

      // Long hold-off on the receiver while pixels keep coming
      write_csr(CSR_IMAGE_WIDTH, 48'd5);
      write_csr(CSR_IMAGE_HEIGHT, 48'd5);
      fork
         begin
            hold_off = 1;
            repeat (60) @(posedge clock);
            hold_off = 0;
         end
         send_frame(5, 5, 2);
      join
      drain();

      // Random phases: frames with random sizes and kernels
      for (int ph = 0; ph < 10; ph++) begin
         int w, h;
         w = $urandom_range(3, 7);
         h = $urandom_range(3, 5);
         if (ph == 5) w = 40;
         if (ph == 5) h = 3;
         write_csr(CSR_IMAGE_WIDTH, 48'(w));
         write_csr(CSR_IMAGE_HEIGHT, 48'(h));
         write_csr(CSR_ANCHOR_ROW, 48'($urandom_range(0, 3)));
         write_csr(CSR_ANCHOR_COL, 48'($urandom_range(0, 3)));
         write_csr(CSR_COEF_ROW0, rand_coef_row());
         write_csr(CSR_COEF_ROW1, rand_coef_row());
         write_csr(CSR_COEF_ROW2, rand_coef_row());
         if (ph == 5) begin
            send_frame(w, h, 2);
         end else begin
            send_frame(w, h, 2);
            // occasional stray frame start mid-stream
            if ($urandom_range(0, 3) == 0) send_pixel(24'($urandom), 1'b1);
            send_frame(w, h, 2);
         end
         drain();
      end

      stim_done = 1;
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
rtl/core/icv_pkg.sv
rtl/core/icv_line_buf.sv
rtl/core/image_convolution_valid_top.sv
tb/image_convolution_valid_top_tb.sv
